// File: rtl/dwsu_pkg.sv
package dwsu_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 14;
   localparam int RSP_DEPTH_DEFAULT   = 4;

   // word classes by top nibble
   localparam logic [3:0] NIB_SAMPLE  = 4'h0;
   localparam logic [3:0] NIB_TIME    = 4'h4;
   localparam logic [3:0] NIB_CHARGE  = 4'h5;
   localparam logic [3:0] NIB_TRIGGER = 4'h8;
   localparam logic [3:0] NIB_STAMP   = 4'hA;
   localparam logic [3:0] NIB_CHANNEL = 4'hC;
   localparam logic [3:0] NIB_MODULE  = 4'hD;
   localparam logic [3:0] NIB_END     = 4'hE;
   localparam logic [3:0] NIB_GROUP   = 4'hF;

   typedef enum logic [2:0] {
      KIND_MODULE     = 3'd0,
      KIND_TRIGGER    = 3'd1,
      KIND_STAMP      = 3'd2,
      KIND_SAMPLES    = 3'd3,
      KIND_CHARGE     = 3'd4,
      KIND_TIME       = 3'd5,
      KIND_SLIP       = 3'd6,
      KIND_UNEXPECTED = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_SKIP   = 3'd1,
      MODE_NAME   = 3'd2,
      MODE_SEEK   = 3'd3,
      MODE_STAMP2 = 3'd4
   } mode_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] module_name;
      logic [3:0]  group_index;
      logic [3:0]  channel_index;
      logic [63:0] value_a;
      logic [23:0] value_b;
      logic        last_of_run;
   } record_type;

   // up to two records per word, packed from slot0
   typedef struct packed {
      logic [1:0] count;
      record_type slot0;
      record_type slot1;
   } push_type;

endpackage

// File: rtl/dwsu_parser.sv
module dwsu_parser #(
   parameter int SAMPLE_BITS = dwsu_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [31:0]       word,
   input  logic              last_word,
   input  logic [23:0]       event_trigger,
   output dwsu_pkg::push_type push
);

   localparam logic [7:0]  TRIG_PREFIX = 8'h80;
   localparam logic [7:0]  SYNC_BYTE   = 8'hD0;
   localparam logic [31:0] WORD_DEAD   = 32'hDEAD_DEAD;
   localparam logic [31:0] WORD_DEAF   = 32'hDEAF_DEAF;
   localparam logic [31:0] WORD_BAD    = 32'hBAD0_BAD0;
   localparam logic [31:0] SKIP_BASE   = 32'hFFFF_FFF0;

   dwsu_pkg::mode_type mode_ff, mode_in, handle_mode;
   logic [31:0] module_ff, module_in;
   logic        grp_valid_ff, grp_valid_in;
   logic [3:0]  grp_ff, grp_in;
   logic        chan_valid_ff, chan_valid_in;
   logic [3:0]  chan_ff, chan_in;
   logic [3:0]  prev_nib_ff, prev_nib_in;
   logic [63:0] charge_ff, charge_in;
   logic [1:0]  parts_ff, parts_in;
   logic [23:0] stamp_ff, stamp_in;

   logic [3:0]  nib;
   logic [23:0] w24;
   logic        trig_hit;
   logic [4:0]  grp_plus1;
   logic        skip_hit;
   logic        do_handle;

   dwsu_pkg::record_type pre_rec, main_rec;
   logic                 pre_valid, main_valid;

   assign nib       = word[31:28];
   assign w24       = word[23:0];
   assign trig_hit  = (word == {TRIG_PREFIX, event_trigger});
   assign grp_plus1 = grp_valid_ff ? ({1'b0, grp_ff} + 5'd1) : 5'd0;
   assign skip_hit  = (word == (SKIP_BASE + {27'd0, grp_plus1})) || (word[31:24] == SYNC_BYTE);
   assign do_handle = (mode_ff == dwsu_pkg::MODE_NORMAL) ||
                      ((mode_ff == dwsu_pkg::MODE_SKIP) && skip_hit);

   // mode a word leaves behind when decoded normally
   always_comb begin
      handle_mode = dwsu_pkg::MODE_NORMAL;
      case (nib)
         dwsu_pkg::NIB_TRIGGER: begin
            if (!trig_hit) handle_mode = dwsu_pkg::MODE_SEEK;
         end
         dwsu_pkg::NIB_STAMP:   handle_mode = dwsu_pkg::MODE_STAMP2;
         dwsu_pkg::NIB_MODULE: begin
            if (word != WORD_DEAD && word != WORD_DEAF) handle_mode = dwsu_pkg::MODE_NAME;
         end
         dwsu_pkg::NIB_END:     handle_mode = dwsu_pkg::MODE_SKIP;
         default:               handle_mode = dwsu_pkg::MODE_NORMAL;
      endcase
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         dwsu_pkg::MODE_SKIP: begin
            if (skip_hit) mode_in = handle_mode;
         end
         dwsu_pkg::MODE_NAME:   mode_in = dwsu_pkg::MODE_NORMAL;
         dwsu_pkg::MODE_SEEK: begin
            if (trig_hit) mode_in = dwsu_pkg::MODE_NORMAL;
         end
         dwsu_pkg::MODE_STAMP2: mode_in = dwsu_pkg::MODE_NORMAL;
         default:               mode_in = handle_mode;
      endcase
      if (last_word) mode_in = dwsu_pkg::MODE_NORMAL;
   end

   // context, charge gathering and records
   always_comb begin
      logic [63:0]        placed;
      logic               take_trig;
      dwsu_pkg::kind_type mkind;
      logic [63:0]        ma;
      logic [23:0]        mb;

      module_in     = module_ff;
      grp_valid_in  = grp_valid_ff;
      grp_in        = grp_ff;
      chan_valid_in = chan_valid_ff;
      chan_in       = chan_ff;
      charge_in     = charge_ff;
      parts_in      = parts_ff;
      stamp_in      = stamp_ff;
      prev_nib_in   = nib;
      take_trig     = 1'b0;
      main_valid    = 1'b0;
      mkind         = dwsu_pkg::KIND_UNEXPECTED;
      ma            = 64'd0;
      mb            = 24'd0;

      case (parts_ff)
         2'd0:    placed = {40'd0, w24};
         2'd1:    placed = {16'd0, w24, 24'd0};
         default: placed = {w24[15:0], 48'd0};
      endcase

      // charge still held is issued ahead of this word's record
      pre_valid = 1'b0;
      pre_rec.kind          = dwsu_pkg::KIND_CHARGE;
      pre_rec.module_name   = module_ff;
      pre_rec.group_index   = grp_valid_ff ? grp_ff : 4'd0;
      pre_rec.channel_index = chan_valid_ff ? chan_ff : 4'd0;
      pre_rec.value_a       = charge_ff;
      pre_rec.value_b       = 24'd0;
      pre_rec.last_of_run   = 1'b0;
      if (parts_ff != 2'd0 &&
          !(mode_ff == dwsu_pkg::MODE_NORMAL && nib == dwsu_pkg::NIB_CHARGE)) begin
         pre_valid = chan_valid_ff;
         charge_in = 64'd0;
         parts_in  = 2'd0;
      end

      if (mode_ff == dwsu_pkg::MODE_NAME) begin
         module_in     = word;
         grp_valid_in  = 1'b0;
         chan_valid_in = 1'b0;
         main_valid    = 1'b1;
         mkind         = dwsu_pkg::KIND_MODULE;
      end else if (mode_ff == dwsu_pkg::MODE_SEEK) begin
         take_trig = trig_hit;
      end else if (mode_ff == dwsu_pkg::MODE_STAMP2) begin
         main_valid = 1'b1;
         mkind      = dwsu_pkg::KIND_STAMP;
         ma         = {40'd0, stamp_ff};
         mb         = w24;
      end else if (do_handle) begin
         case (nib)
            dwsu_pkg::NIB_SAMPLE: begin
               main_valid = (word != 32'd0) && chan_valid_ff;
               mkind      = dwsu_pkg::KIND_SAMPLES;
               ma         = 64'(word[SAMPLE_BITS-1:0]);
               mb         = 24'(word[16 +: SAMPLE_BITS]);
            end
            dwsu_pkg::NIB_TIME: begin
               main_valid = chan_valid_ff;
               mkind      = dwsu_pkg::KIND_TIME;
               ma         = {40'd0, w24};
            end
            dwsu_pkg::NIB_CHARGE: begin
               if (parts_ff == 2'd2) begin
                  main_valid = chan_valid_ff;
                  mkind      = dwsu_pkg::KIND_CHARGE;
                  ma         = charge_ff | placed;
                  charge_in  = 64'd0;
                  parts_in   = 2'd0;
               end else begin
                  charge_in = charge_ff | placed;
                  parts_in  = parts_ff + 2'd1;
               end
            end
            dwsu_pkg::NIB_TRIGGER: take_trig = trig_hit;
            dwsu_pkg::NIB_STAMP:   stamp_in = w24;
            dwsu_pkg::NIB_CHANNEL: begin
               chan_valid_in = 1'b1;
               chan_in       = word[3:0];
            end
            dwsu_pkg::NIB_MODULE: begin
               main_valid = (word == WORD_DEAF);
               mkind      = dwsu_pkg::KIND_SLIP;
               ma         = {32'd0, word};
            end
            dwsu_pkg::NIB_END:     chan_valid_in = 1'b0;
            dwsu_pkg::NIB_GROUP: begin
               grp_valid_in = 1'b1;
               grp_in       = word[3:0];
            end
            default: begin
               main_valid = 1'b1;
               mkind      = (word == WORD_BAD) ? dwsu_pkg::KIND_SLIP :
                                                 dwsu_pkg::KIND_UNEXPECTED;
               ma         = {32'd0, word};
            end
         endcase
      end

      if (take_trig) begin
         if (prev_nib_ff != dwsu_pkg::NIB_GROUP) begin
            grp_valid_in = 1'b1;
            grp_in       = !grp_valid_ff ? 4'd0 : (grp_ff == 4'hF) ? 4'hF : grp_ff + 4'd1;
         end
         chan_valid_in = 1'b0;
         main_valid    = 1'b1;
         mkind         = dwsu_pkg::KIND_TRIGGER;
         ma            = {40'd0, w24};
      end

      // end of buffer: charge still gathering goes out (never with a main record)
      if (last_word && parts_in != 2'd0) begin
         main_valid = chan_valid_in;
         mkind      = dwsu_pkg::KIND_CHARGE;
         ma         = charge_in;
      end

      main_rec.kind          = mkind;
      main_rec.module_name   = module_in;
      main_rec.group_index   = grp_valid_in ? grp_in : 4'd0;
      main_rec.channel_index = chan_valid_in ? chan_in : 4'd0;
      main_rec.value_a       = ma;
      main_rec.value_b       = mb;
      main_rec.last_of_run   = 1'b1;
      pre_rec.last_of_run    = !main_valid;

      if (last_word) begin
         module_in     = 32'd0;
         grp_valid_in  = 1'b0;
         grp_in        = 4'd0;
         chan_valid_in = 1'b0;
         chan_in       = 4'd0;
         prev_nib_in   = 4'd0;
         charge_in     = 64'd0;
         parts_in      = 2'd0;
         stamp_in      = 24'd0;
      end
   end

   always_comb begin
      push.slot0 = pre_valid ? pre_rec : main_rec;
      push.slot1 = main_rec;
      if (!accept)                     push.count = 2'd0;
      else if (pre_valid && main_valid) push.count = 2'd2;
      else if (pre_valid || main_valid) push.count = 2'd1;
      else                             push.count = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= dwsu_pkg::MODE_NORMAL;
         module_ff     <= 32'd0;
         grp_valid_ff  <= 1'b0;
         grp_ff        <= 4'd0;
         chan_valid_ff <= 1'b0;
         chan_ff       <= 4'd0;
         prev_nib_ff   <= 4'd0;
         charge_ff     <= 64'd0;
         parts_ff      <= 2'd0;
         stamp_ff      <= 24'd0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         module_ff     <= module_in;
         grp_valid_ff  <= grp_valid_in;
         grp_ff        <= grp_in;
         chan_valid_ff <= chan_valid_in;
         chan_ff       <= chan_in;
         prev_nib_ff   <= prev_nib_in;
         charge_ff     <= charge_in;
         parts_ff      <= parts_in;
         stamp_ff      <= stamp_in;
      end
   end

`ifndef SYNTHESIS
   a_parts_below_three: assert property (@(posedge clock) disable iff (reset)
      parts_ff != 2'd3)
      else $error("charge part count reached three while held");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && last_word) |=>
         (mode_ff == dwsu_pkg::MODE_NORMAL && parts_ff == 2'd0 && !grp_valid_ff &&
          !chan_valid_ff && module_ff == 32'd0))
      else $error("state not cleared after the last word of a buffer");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.slot0.kind == dwsu_pkg::KIND_CHARGE &&
                                !push.slot0.last_of_run && push.slot1.last_of_run))
      else $error("two records from one word not a charge followed by the final record");
`endif

endmodule

// File: rtl/dwsu_rsp_queue.sv
module dwsu_rsp_queue #(
   parameter int DEPTH = dwsu_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dwsu_pkg::push_type   push,
   input  logic                 pop,
   output logic                 in_ready,
   output logic                 out_valid,
   output dwsu_pkg::record_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dwsu_pkg::record_type entries_ff [DEPTH];

   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in, wp1;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] step(input logic [PTR_W-1:0] p);
      step = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wp1       = step(wp_ff);
   assign in_ready  = (count_ff <= CNT_W'(DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign head      = entries_ff[rp_ff];

   always_comb begin
      case (push.count)
         2'd1:    wp_in = wp1;
         2'd2:    wp_in = step(wp1);
         default: wp_in = wp_ff;
      endcase
      rp_in    = pop ? step(rp_ff) : rp_ff;
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entries_ff[wp_ff] <= push.slot0;
      if (push.count == 2'd2) entries_ff[wp1]   <= push.slot1;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("response queue over capacity");

   a_room_for_pair: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (count_ff <= CNT_W'(DEPTH - 2)))
      else $error("records written without room for a pair");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> (count_ff + CNT_W'(1) == $past(count_ff)))
      else $error("transfer out did not free an entry");
`endif

endmodule

// File: rtl/digitizer_word_stream_unpacker_core.sv
// Latency: a record is offered on rsp_valid the cycle after its word is taken if
// no earlier record is queued. Throughput, while rsp_ready is high: one word per
// cycle while each word gives at most one record; a word that also releases
// held charge gives two records, and the single rsp port then drains the
// four-entry record queue at one record per cycle. Reset (synchronous, active
// high) clears the parse context, the queue and the event_trigger register to zero.
module digitizer_word_stream_unpacker_core #(
   parameter int SAMPLE_BITS = dwsu_pkg::SAMPLE_BITS_DEFAULT,
   parameter int RSP_DEPTH   = dwsu_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_word,
   input  logic        req_last_word,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_module_name,
   output logic [3:0]  rsp_group_index,
   output logic [3:0]  rsp_channel_index,
   output logic [63:0] rsp_value_a,
   output logic [23:0] rsp_value_b,
   output logic        rsp_last_of_run,

   input  logic        csr_write_enable,
   input  logic [23:0] csr_write_data
);

   logic [23:0]          event_trigger_ff;
   logic                 accept;
   dwsu_pkg::push_type   push;
   dwsu_pkg::record_type head;

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         event_trigger_ff <= 24'd0;
      end else if (csr_write_enable) begin
         event_trigger_ff <= csr_write_data;
      end
   end

   dwsu_parser #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .word          (req_word),
      .last_word     (req_last_word),
      .event_trigger (event_trigger_ff),
      .push          (push)
   );

   dwsu_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_valid && rsp_ready),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .head      (head)
   );

   assign rsp_kind          = head.kind;
   assign rsp_module_name   = head.module_name;
   assign rsp_group_index   = head.group_index;
   assign rsp_channel_index = head.channel_index;
   assign rsp_value_a       = head.value_a;
   assign rsp_value_b       = head.value_b;
   assign rsp_last_of_run   = head.last_of_run;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int SAMPLE_BITS = dwsu_pkg::SAMPLE_BITS_DEFAULT;
   localparam logic [31:0] SAMPLE_MASK = (32'd1 << SAMPLE_BITS) - 32'd1;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int TAIL_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_WORDS = 115;

   // one bit per nibble that has a meaning of its own
   localparam logic [15:0] KNOWN_NIBBLES = 16'b1111_0101_0011_0001;

   localparam logic [31:0] IGNORE_WORD  = 32'hDEAD_DEAD;
   localparam logic [31:0] SLIP_MARK    = 32'hDEAF_DEAF;
   localparam logic [31:0] SLIP_WORD    = 32'hBAD0_BAD0;
   localparam logic [31:0] TRIGGER_BASE = 32'h8000_0000;
   localparam logic [31:0] SKIP_BASE    = 32'hFFFF_FFF0;
   localparam logic [7:0]  MODULE_BYTE  = 8'hD0;

   class unpack_scoreboard;
      dwsu_pkg::record_type awaited_records[$];
      logic [23:0]          trigger_number;
      dwsu_pkg::mode_type   mode;
      logic [31:0]          cur_module;
      int                   cur_group;
      int                   cur_channel;
      logic [3:0]           prev_nibble;
      logic [63:0]          charge_sum;
      int                   charge_parts;
      logic [23:0]          first_stamp;
      int                   mismatches;
      int                   checked;
      int                   kind_seen[8];

      function new();
         trigger_number = 24'd0;
         mismatches = 0;
         checked = 0;
         foreach (kind_seen[i]) kind_seen[i] = 0;
         clear_context();
      endfunction

      function void clear_context();
         mode = dwsu_pkg::MODE_NORMAL;
         cur_module = 32'd0;
         cur_group = -1;
         cur_channel = -1;
         prev_nibble = 4'd0;
         charge_sum = 64'd0;
         charge_parts = 0;
         first_stamp = 24'd0;
      endfunction

      function int pending();
         return awaited_records.size();
      endfunction

      function logic [31:0] trigger_word();
         return TRIGGER_BASE + {8'd0, trigger_number};
      endfunction

      function logic [31:0] skip_target();
         return SKIP_BASE + 32'(cur_group + 1);
      endfunction

      function void emit(dwsu_pkg::kind_type k, logic [63:0] a, logic [23:0] b);
         dwsu_pkg::record_type r;
         r.kind = k;
         r.module_name = cur_module;
         r.group_index = cur_group < 0 ? 4'd0 : 4'(cur_group);
         r.channel_index = cur_channel < 0 ? 4'd0 : 4'(cur_channel);
         r.value_a = a;
         r.value_b = b;
         r.last_of_run = 1'b0;
         awaited_records.insert(awaited_records.size(), r);
      endfunction

      function void flush_charge();
         if (charge_parts > 0 && cur_channel >= 0)
            emit(dwsu_pkg::KIND_CHARGE, charge_sum, 24'd0);
         charge_sum = 64'd0;
         charge_parts = 0;
      endfunction

      function void take_trigger(logic [31:0] w);
         if (prev_nibble != dwsu_pkg::NIB_GROUP)
            cur_group = cur_group < 15 ? cur_group + 1 : 15;
         cur_channel = -1;
         emit(dwsu_pkg::KIND_TRIGGER, {40'd0, w[23:0]}, 24'd0);
      endfunction

      function void handle_word(logic [31:0] w);
         case (w[31:28])
            dwsu_pkg::NIB_SAMPLE: begin
               if (w != 32'd0 && cur_channel >= 0)
                  emit(dwsu_pkg::KIND_SAMPLES, 64'(w & SAMPLE_MASK),
                       24'((w >> 16) & SAMPLE_MASK));
            end
            dwsu_pkg::NIB_TIME: begin
               if (cur_channel >= 0) emit(dwsu_pkg::KIND_TIME, {40'd0, w[23:0]}, 24'd0);
            end
            dwsu_pkg::NIB_CHARGE: begin
               charge_sum += {40'd0, w[23:0]} << (24 * charge_parts);
               charge_parts++;
               if (charge_parts >= 3) flush_charge();
            end
            dwsu_pkg::NIB_TRIGGER: begin
               if (w == trigger_word()) take_trigger(w);
               else mode = dwsu_pkg::MODE_SEEK;
            end
            dwsu_pkg::NIB_STAMP: begin
               first_stamp = w[23:0];
               mode = dwsu_pkg::MODE_STAMP2;
            end
            dwsu_pkg::NIB_CHANNEL: cur_channel = int'(w[3:0]);
            dwsu_pkg::NIB_MODULE: begin
               if (w != IGNORE_WORD) begin
                  if (w == SLIP_MARK) emit(dwsu_pkg::KIND_SLIP, {32'd0, w}, 24'd0);
                  else mode = dwsu_pkg::MODE_NAME;
               end
            end
            dwsu_pkg::NIB_END: begin
               cur_channel = -1;
               mode = dwsu_pkg::MODE_SKIP;
            end
            dwsu_pkg::NIB_GROUP: cur_group = int'(w[3:0]);
            default: emit(w == SLIP_WORD ? dwsu_pkg::KIND_SLIP : dwsu_pkg::KIND_UNEXPECTED,
                          {32'd0, w}, 24'd0);
         endcase
      endfunction

      // one accepted input transfer: queue up the records it should give
      function void predict_word(logic [31:0] w, logic last);
         int step_base;
         step_base = awaited_records.size();
         if (charge_parts > 0 &&
             !(mode == dwsu_pkg::MODE_NORMAL && w[31:28] == dwsu_pkg::NIB_CHARGE))
            flush_charge();
         case (mode)
            dwsu_pkg::MODE_SKIP: begin
               if (w == skip_target() || w[31:24] == MODULE_BYTE) begin
                  mode = dwsu_pkg::MODE_NORMAL;
                  handle_word(w);
               end
            end
            dwsu_pkg::MODE_NAME: begin
               mode = dwsu_pkg::MODE_NORMAL;
               cur_module = w;
               cur_group = -1;
               cur_channel = -1;
               emit(dwsu_pkg::KIND_MODULE, 64'd0, 24'd0);
            end
            dwsu_pkg::MODE_SEEK: begin
               if (w == trigger_word()) begin
                  mode = dwsu_pkg::MODE_NORMAL;
                  take_trigger(w);
               end
            end
            dwsu_pkg::MODE_STAMP2: begin
               mode = dwsu_pkg::MODE_NORMAL;
               emit(dwsu_pkg::KIND_STAMP, {40'd0, first_stamp}, w[23:0]);
            end
            default: begin
               mode = dwsu_pkg::MODE_NORMAL;
               handle_word(w);
            end
         endcase
         prev_nibble = w[31:28];
         if (last) begin
            flush_charge();
            clear_context();
         end
         if (awaited_records.size() > step_base)
            awaited_records[awaited_records.size() - 1].last_of_run = 1'b1;
      endfunction

      function string show(dwsu_pkg::record_type r);
         return $sformatf("kind=%0d module=%h group=%0d channel=%0d a=%h b=%h last=%b",
                          r.kind, r.module_name, r.group_index, r.channel_index,
                          r.value_a, r.value_b, r.last_of_run);
      endfunction

      function void check_record(dwsu_pkg::record_type got);
         dwsu_pkg::record_type want;
         string diff;
         checked++;
         if (!$isunknown(got.kind)) kind_seen[int'(got.kind)]++;
         if (awaited_records.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: record with none awaited: %s", show(got));
            return;
         end
         want = awaited_records.pop_front();
         diff = "";
         if (got.kind !== want.kind) diff = {diff, " kind"};
         if (got.module_name !== want.module_name) diff = {diff, " module_name"};
         if (got.group_index !== want.group_index) diff = {diff, " group_index"};
         if (got.channel_index !== want.channel_index) diff = {diff, " channel_index"};
         if (got.value_a !== want.value_a) diff = {diff, " value_a"};
         if (got.value_b !== want.value_b) diff = {diff, " value_b"};
         if (got.last_of_run !== want.last_of_run) diff = {diff, " last_of_run"};
         if (diff != "") begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: record %0d differs in%s", checked, diff);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_word = 32'd0;
   logic        req_last_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_module_name;
   logic [3:0]  rsp_group_index;
   logic [3:0]  rsp_channel_index;
   logic [63:0] rsp_value_a;
   logic [23:0] rsp_value_b;
   logic        rsp_last_of_run;
   logic        csr_write_enable = 1'b0;
   logic [23:0] csr_write_data = 24'd0;

   dwsu_pkg::record_type rsp_record;
   unpack_scoreboard     sb = new();

   int cycle_count = 0;
   int words_sent = 0;
   int burst_left = 0;
   bit steady_sender = 0;
   int hold_orders = 0;
   int holds_done = 0;
   int hold_left = 0;
   int rx_cycle = 0;
   int rx_style = 0;

   digitizer_word_stream_unpacker_core #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .req_last_word(req_last_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_module_name(rsp_module_name),
      .rsp_group_index(rsp_group_index),
      .rsp_channel_index(rsp_channel_index),
      .rsp_value_a(rsp_value_a),
      .rsp_value_b(rsp_value_b),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   assign rsp_record = {rsp_kind, rsp_module_name, rsp_group_index, rsp_channel_index,
                        rsp_value_a, rsp_value_b, rsp_last_of_run};

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d records outstanding",
                  cycle_count, sb.pending());
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.predict_word(req_word, req_last_word);
         if (rsp_valid && rsp_ready) sb.check_record(rsp_record);
      end
   end

   // receiver: switches among four ready styles at random, plus long hold-offs on request
   always @(negedge clock) begin
      if (holds_done != hold_orders) begin
         holds_done = hold_orders;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 64 == 0) rx_style = $urandom_range(0, 3);
         case (rx_style)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= (rx_cycle % 4 == 0);
            default: rsp_ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 24);
      if (!steady_sender) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic push_word(input logic [31:0] w, input logic last);
      req_valid <= 1'b1;
      req_word <= w;
      req_last_word <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
      pace();
   endtask

   // stop offering and wait for every awaited record; optional tail for held charge
   task automatic settle(input bit with_tail);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      if (with_tail) repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic write_trigger(input logic [23:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      sb.trigger_number = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic push_odd_word();
      logic [31:0] w;
      do w = $urandom; while (KNOWN_NIBBLES[w[31:28]]);
      push_word(w, 1'b0);
   endtask

   task automatic push_channel_data();
      int n_rec;
      n_rec = $urandom_range(1, 6);
      repeat (n_rec) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: push_word({dwsu_pkg::NIB_SAMPLE, 28'($urandom)}, 1'b0);
            4, 5: repeat ($urandom_range(1, 4))
               push_word({dwsu_pkg::NIB_CHARGE, 28'($urandom)}, 1'b0);
            6, 7: push_word({dwsu_pkg::NIB_TIME, 28'($urandom)}, 1'b0);
            8: begin
               case ($urandom_range(0, 4))
                  0: push_word(IGNORE_WORD, 1'b0);
                  1: push_word(SLIP_MARK, 1'b0);
                  2: push_word(SLIP_WORD, 1'b0);
                  3: push_word(32'd0, 1'b0);
                  default: push_odd_word();
               endcase
            end
            default: push_word($urandom, 1'b0);
         endcase
      end
   endtask

   // one event buffer: modules, groups, channels with random content, last word closes it
   task automatic send_buffer();
      int n_mod;
      int n_grp;
      int n_chan;
      logic [31:0] w;
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) push_word($urandom, 1'b0);
      n_mod = $urandom_range(1, 2);
      for (int m = 0; m < n_mod; m++) begin
         if ($urandom_range(0, 7) != 0) begin
            w = {dwsu_pkg::NIB_MODULE, 28'($urandom)};
            if (w == IGNORE_WORD || w == SLIP_MARK) w[0] = ~w[0];
            push_word(w, 1'b0);
            push_word($urandom, 1'b0);
         end
         n_grp = $urandom_range(1, 4);
         for (int g = 0; g < n_grp; g++) begin
            if ($urandom_range(0, 2) == 0)
               push_word({dwsu_pkg::NIB_GROUP, 28'($urandom)}, 1'b0);
            if ($urandom_range(0, 5) == 0) begin
               // wrong trigger first: the block has to seek
               push_word({dwsu_pkg::NIB_TRIGGER, 28'($urandom)}, 1'b0);
               repeat ($urandom_range(0, 3)) push_word($urandom, 1'b0);
            end
            push_word(sb.trigger_word(), 1'b0);
            if ($urandom_range(0, 3) != 0) begin
               push_word({dwsu_pkg::NIB_STAMP, 28'($urandom)}, 1'b0);
               push_word($urandom, 1'b0);
            end
            n_chan = $urandom_range(0, 3);
            repeat (n_chan) begin
               push_word({dwsu_pkg::NIB_CHANNEL, 28'($urandom)}, 1'b0);
               push_channel_data();
            end
            if ($urandom_range(0, 3) == 0) begin
               push_word({dwsu_pkg::NIB_END, 28'($urandom)}, 1'b0);
               repeat ($urandom_range(0, 3)) push_word($urandom, 1'b0);
               if ($urandom_range(0, 2) != 0) begin
                  push_word(sb.skip_target(), 1'b0);
               end else begin
                  push_word({MODULE_BYTE, 24'($urandom)}, 1'b0);
                  push_word($urandom, 1'b0);
               end
            end
         end
      end
      case ($urandom_range(0, 5))
         0: push_word({dwsu_pkg::NIB_CHARGE, 28'($urandom)}, 1'b1);
         1: push_word({dwsu_pkg::NIB_STAMP, 28'($urandom)}, 1'b1);
         2: push_word({dwsu_pkg::NIB_MODULE, 28'($urandom)}, 1'b1);
         3: push_word({dwsu_pkg::NIB_END, 28'($urandom)}, 1'b1);
         4: push_word(32'd0, 1'b1);
         default: push_word($urandom, 1'b1);
      endcase
   endtask

   task automatic run_phase(input logic [23:0] setting, input bit squeeze);
      int stop_at;
      settle(1'b1);
      write_trigger(setting);
      stop_at = words_sent + PHASE_WORDS;
      if (squeeze) begin
         hold_orders++;
         steady_sender = 1'b1;
      end
      while (words_sent < stop_at) begin
         send_buffer();
         steady_sender = 1'b0;
         if ($urandom_range(0, 7) == 0) settle(1'b0);
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // no channel yet: samples and time dropped
      push_word(32'h0FFF_FFFF, 1'b0);
      push_word(32'h4123_4567, 1'b0);
      // trigger matches the reset value; group header then saturation at 15
      push_word(32'h8000_0000, 1'b0);
      push_word(32'hF000_000F, 1'b0);
      push_word(32'h8000_0000, 1'b0);
      push_word(32'h8000_0000, 1'b0);
      push_word(32'hC000_000F, 1'b0);
      push_word(32'h0FFF_FFFF, 1'b0);
      // three full charge parts, then one part released by a time word
      push_word(32'h5FFF_FFFF, 1'b0);
      push_word(32'h5FFF_FFFF, 1'b0);
      push_word(32'h5FFF_FFFF, 1'b0);
      push_word(32'h5000_0001, 1'b0);
      push_word(32'h4ABC_DEF0, 1'b0);
      push_word(32'hAFFF_FFFF, 1'b0);
      push_word(32'hFFFF_FFFF, 1'b0);
      push_word(IGNORE_WORD, 1'b0);
      push_word(SLIP_MARK, 1'b0);
      push_word(SLIP_WORD, 1'b0);
      push_word(32'h7FFF_FFFF, 1'b0);
      // end marker in group 15: the skip target wraps round to zero
      push_word(32'hE000_0000, 1'b0);
      push_word(32'h8000_0000, 1'b0);
      push_word(32'h0000_0000, 1'b0);
      push_word(32'h8000_0001, 1'b0);
      push_word(32'h8000_0000, 1'b0);
      push_word(32'hD123_4567, 1'b0);
      push_word(32'hFFFF_FFFF, 1'b0);
      push_word(32'hC000_0000, 1'b0);
      // charge still held when the buffer ends
      push_word(32'h5000_0002, 1'b1);

      run_phase(24'hFF_FFFF, 1'b0);
      run_phase(24'h00_0001, 1'b1);
      run_phase(24'($urandom), 1'b0);
      run_phase(24'h80_0000, 1'b0);
      run_phase(24'($urandom), 1'b0);
      run_phase(24'h00_0000, 1'b0);
      settle(1'b1);

      $display("Run covered %0d words under six trigger settings, both extremes included;",
               words_sent);
      $display("%0d records checked, %0d mismatches", sb.checked, sb.mismatches);
      $display("Records by kind: module %0d trigger %0d stamp %0d samples %0d",
               sb.kind_seen[dwsu_pkg::KIND_MODULE], sb.kind_seen[dwsu_pkg::KIND_TRIGGER],
               sb.kind_seen[dwsu_pkg::KIND_STAMP], sb.kind_seen[dwsu_pkg::KIND_SAMPLES]);
      $display("   charge %0d time %0d slip %0d unexpected %0d",
               sb.kind_seen[dwsu_pkg::KIND_CHARGE], sb.kind_seen[dwsu_pkg::KIND_TIME],
               sb.kind_seen[dwsu_pkg::KIND_SLIP], sb.kind_seen[dwsu_pkg::KIND_UNEXPECTED]);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
